// ===== src/mpsf_pkg.sv =====
package mpsf_pkg;

  localparam int MAX_FILTERS = 16;
  localparam int PATTERN_LEN = 64;

  localparam int IDX_W = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;
  localparam int LEN_W = $clog2(PATTERN_LEN + 1);
  localparam int FLT_W = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int CNT_W = $clog2(MAX_FILTERS + 1);
  localparam int TBL_DEPTH = MAX_FILTERS * PATTERN_LEN;
  localparam int TBL_AW = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_DEL   = 2'd2,
    OP_MSG   = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       last;
    logic [2:0] prio;
  } cmd_t;

  typedef struct packed {
    logic [4:0] pattern_count;
    logic       pass;
    logic [1:0] status;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CMP,
    S_ADD_RD,
    S_ADD_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_MSG_RD,
    S_MSG_CMP,
    S_MSG_END
  } state_t;

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [FLT_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
    int a;
    a = int'(row) * PATTERN_LEN + int'(col);
    return TBL_AW'(a);
  endfunction

  // position of byte col of the newest len bytes in the ring
  function automatic logic [IDX_W-1:0] win_addr(input logic [IDX_W-1:0] head,
                                                input logic [LEN_W-1:0] len,
                                                input logic [IDX_W-1:0] col);
    int s;
    s = int'(head) + PATTERN_LEN - int'(len) + int'(col);
    if (s >= PATTERN_LEN) s = s - PATTERN_LEN;
    if (s >= PATTERN_LEN) s = s - PATTERN_LEN;
    return IDX_W'(s);
  endfunction

endpackage

// ===== src/mpsf_ram.sv =====
module mpsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mpsf_front.sv =====
module mpsf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [15:0]    s_tdata,
  input  logic [1:0]     s_tuser,
  input  logic           s_tlast,
  output logic           q_valid,
  output mpsf_pkg::cmd_t q_cmd,
  input  logic           q_pop
);
  import mpsf_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  cmd_t              cmd_in;

  // classify the incoming transaction
  always_comb begin
    cmd_in.op = op_t'(s_tuser);
    cmd_in.data_byte = s_tdata[7:0];
    cmd_in.last = s_tlast;
    cmd_in.prio = s_tdata[10:8];
  end

  assign s_tready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign push = s_tvalid && s_tready;
  assign q_valid = (fill != '0);
  assign q_cmd = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (q_pop) rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !q_pop) fill <= fill + 1'b1;
      else if (!push && q_pop) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= cmd_in;
  end

endmodule

// ===== src/mpsf_back.sv =====
module mpsf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  mpsf_pkg::cmd_t q_cmd,
  output logic           q_pop,
  input  logic [2:0]     filtered_priority,
  output logic           out_valid,
  output mpsf_pkg::res_t out_res,
  input  logic           out_ready
);
  import mpsf_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [LEN_W-1:0] lens [MAX_FILTERS];
  logic [LEN_W-1:0] inc_len, inc_len_next;
  logic             inc_ended, inc_ended_next;
  logic [IDX_W-1:0] head, head_next;
  logic [LEN_W-1:0] fill, fill_next;
  logic             match_seen, match_seen_next;
  logic [CNT_W-1:0] k, k_next;
  logic [LEN_W-1:0] j, j_next;
  cmd_t             cur, cur_next;
  logic             out_valid_next;
  res_t             out_res_next;

  logic             len_we;
  logic [FLT_W-1:0] len_wa;
  logic [LEN_W-1:0] len_wd;

  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_wa, tbl_ra;
  logic [7:0]        tbl_wd, tbl_rd;
  logic              inc_we;
  logic [IDX_W-1:0]  inc_wa, inc_ra;
  logic [7:0]        inc_wd, inc_rd;
  logic              win_we;
  logic [IDX_W-1:0]  win_ra;
  logic [7:0]        win_rd;

  logic [FLT_W-1:0] k_idx, k1_idx;
  logic [IDX_W-1:0] j_idx;
  logic [LEN_W-1:0] len_k;

  assign k_idx = k[FLT_W-1:0];
  assign k1_idx = FLT_W'(k + 1'b1);
  assign j_idx = j[IDX_W-1:0];
  assign len_k = lens[k_idx];

  mpsf_ram #(.WIDTH(8), .DEPTH(TBL_DEPTH)) u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_wa), .wdata(tbl_wd), .raddr(tbl_ra), .rdata(tbl_rd)
  );

  mpsf_ram #(.WIDTH(8), .DEPTH(PATTERN_LEN)) u_incoming (
    .clk(clk), .we(inc_we), .waddr(inc_wa), .wdata(inc_wd), .raddr(inc_ra), .rdata(inc_rd)
  );

  mpsf_ram #(.WIDTH(8), .DEPTH(PATTERN_LEN)) u_window (
    .clk(clk), .we(win_we), .waddr(head), .wdata(q_cmd.data_byte), .raddr(win_ra),
    .rdata(win_rd)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    inc_len_next = inc_len;
    inc_ended_next = inc_ended;
    head_next = head;
    fill_next = fill;
    match_seen_next = match_seen;
    k_next = k;
    j_next = j;
    cur_next = cur;
    out_valid_next = out_valid && !out_ready;
    out_res_next = out_res;
    q_pop = 1'b0;
    len_we = 1'b0;
    len_wa = k_idx;
    len_wd = inc_len;
    tbl_we = 1'b0;
    tbl_wa = tbl_addr(k_idx, j_idx);
    tbl_wd = inc_rd;
    tbl_ra = tbl_addr(k_idx, j_idx);
    inc_we = 1'b0;
    inc_wa = inc_len[IDX_W-1:0];
    inc_wd = q_cmd.data_byte;
    inc_ra = j_idx;
    win_we = 1'b0;
    win_ra = win_addr(head, len_k, j_idx);

    unique case (state)
      S_IDLE: begin
        if (q_valid && !out_valid) begin
          q_pop = 1'b1;
          cur_next = q_cmd;
          k_next = '0;
          j_next = '0;
          unique case (q_cmd.op)
            OP_CLEAR: begin
              count_next = '0;
              out_valid_next = 1'b1;
              out_res_next = '{pattern_count: 5'd0, pass: 1'b0, status: ST_OK};
            end
            OP_ADD, OP_DEL: begin
              if (!inc_ended) begin
                if (q_cmd.data_byte == 8'd0) begin
                  inc_ended_next = 1'b1;
                end else if (inc_len < LEN_W'(PATTERN_LEN)) begin
                  inc_we = 1'b1;
                  inc_len_next = inc_len + 1'b1;
                end
              end
              if (q_cmd.last) begin
                if (q_cmd.op == OP_ADD && count >= CNT_W'(MAX_FILTERS)) begin
                  out_valid_next = 1'b1;
                  out_res_next = '{pattern_count: 5'(count), pass: 1'b0, status: ST_FULL};
                  inc_len_next = '0;
                  inc_ended_next = 1'b0;
                end else begin
                  state_next = S_FIND_RD;
                end
              end
            end
            OP_MSG: begin
              win_we = 1'b1;
              head_next = (head == IDX_W'(PATTERN_LEN - 1)) ? '0 : head + 1'b1;
              if (fill < LEN_W'(PATTERN_LEN)) fill_next = fill + 1'b1;
              if (!match_seen && count != '0) state_next = S_MSG_RD;
              else state_next = S_MSG_END;
            end
            default: ;
          endcase
        end
      end

      S_FIND_RD: begin
        if (k == count) begin
          if (cur.op == OP_ADD && inc_len != '0) begin
            j_next = '0;
            state_next = S_ADD_RD;
          end else begin
            out_valid_next = 1'b1;
            out_res_next = '{pattern_count: 5'(count), pass: 1'b0, status: ST_REJECT};
            inc_len_next = '0;
            inc_ended_next = 1'b0;
            state_next = S_IDLE;
          end
        end else if (len_k != inc_len) begin
          k_next = k + 1'b1;
        end else if (j == inc_len) begin
          if (cur.op == OP_ADD) begin
            out_valid_next = 1'b1;
            out_res_next = '{pattern_count: 5'(count), pass: 1'b0, status: ST_REJECT};
            inc_len_next = '0;
            inc_ended_next = 1'b0;
            state_next = S_IDLE;
          end else begin
            j_next = '0;
            state_next = S_DEL_RD;
          end
        end else begin
          state_next = S_FIND_CMP;
        end
      end

      S_FIND_CMP: begin
        if (tbl_rd == inc_rd) begin
          j_next = j + 1'b1;
        end else begin
          k_next = k + 1'b1;
          j_next = '0;
        end
        state_next = S_FIND_RD;
      end

      S_ADD_RD: begin
        if (j == inc_len) begin
          len_we = 1'b1;
          len_wa = count[FLT_W-1:0];
          count_next = count + 1'b1;
          out_valid_next = 1'b1;
          out_res_next = '{pattern_count: 5'(count + 1'b1), pass: 1'b0, status: ST_OK};
          inc_len_next = '0;
          inc_ended_next = 1'b0;
          state_next = S_IDLE;
        end else begin
          state_next = S_ADD_WR;
        end
      end

      S_ADD_WR: begin
        tbl_we = 1'b1;
        tbl_wa = tbl_addr(count[FLT_W-1:0], j_idx);
        j_next = j + 1'b1;
        state_next = S_ADD_RD;
      end

      S_DEL_RD: begin
        tbl_ra = tbl_addr(k1_idx, j_idx);
        if (k + 1'b1 >= count) begin
          count_next = count - 1'b1;
          out_valid_next = 1'b1;
          out_res_next = '{pattern_count: 5'(count - 1'b1), pass: 1'b0, status: ST_OK};
          inc_len_next = '0;
          inc_ended_next = 1'b0;
          state_next = S_IDLE;
        end else if (j == LEN_W'(PATTERN_LEN)) begin
          len_we = 1'b1;
          len_wd = lens[k1_idx];
          k_next = k + 1'b1;
          j_next = '0;
        end else begin
          state_next = S_DEL_WR;
        end
      end

      S_DEL_WR: begin
        tbl_we = 1'b1;
        tbl_wd = tbl_rd;
        j_next = j + 1'b1;
        state_next = S_DEL_RD;
      end

      S_MSG_RD: begin
        if (k == count) begin
          state_next = S_MSG_END;
        end else if (len_k == '0 || len_k > fill) begin
          k_next = k + 1'b1;
        end else if (j == len_k) begin
          match_seen_next = 1'b1;
          state_next = S_MSG_END;
        end else begin
          state_next = S_MSG_CMP;
        end
      end

      S_MSG_CMP: begin
        if (tbl_rd == win_rd) begin
          j_next = j + 1'b1;
        end else begin
          k_next = k + 1'b1;
          j_next = '0;
        end
        state_next = S_MSG_RD;
      end

      S_MSG_END: begin
        if (cur.last) begin
          out_valid_next = 1'b1;
          out_res_next = '{pattern_count: 5'(count),
                           pass: (cur.prio < filtered_priority) || match_seen,
                           status: ST_OK};
          fill_next = '0;
          match_seen_next = 1'b0;
        end
        state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      inc_len <= '0;
      inc_ended <= 1'b0;
      head <= '0;
      fill <= '0;
      match_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      inc_len <= inc_len_next;
      inc_ended <= inc_ended_next;
      head <= head_next;
      fill <= fill_next;
      match_seen <= match_seen_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k <= k_next;
    j <= j_next;
    cur <= cur_next;
    out_res <= out_res_next;
    if (len_we) lens[len_wa] <= len_wd;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_FILTERS)) else $error("pattern count above table size");
  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !out_valid && state == S_IDLE) else $error("pop while busy");
  a_inc_bound: assert property (@(posedge clk) disable iff (rst)
    inc_len <= LEN_W'(PATTERN_LEN)) else $error("incoming pattern overrun");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LEN_W'(PATTERN_LEN)) else $error("window fill overrun");
`endif

endmodule

// ===== src/multi_pattern_substring_filter.sv =====
// multi-pattern substring filter
// slave stream s_*: one transaction per byte; tuser carries the operation
// (clear table, add-pattern byte, delete-pattern byte, message byte), tdata
// the byte and the message priority, tlast ends a pattern or a message
// master stream m_*: one result transaction per clear, per completed pattern
// and per completed message; other bytes give no result
// a two-entry queue takes input transactions while the engine works or while
// a result waits on m_tready; when the receiver stalls the result register
// holds and the queue fills, then s_tready drops
// search: the stored patterns are compared byte by byte through the single
// pattern memory read port; a message byte is matched against the window of
// newest message bytes, an add or delete first looks for an equal stored
// pattern, then an add copies the new pattern into the next free row and a
// delete moves every later row down by one, PATTERN_LEN bytes each
// reset: table empty, filtered_priority 7, no clearing pass is needed
// apb: register filtered_priority at address 0, pready always high
module multi_pattern_substring_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // data_byte [7:0], priority_req [10:8], zero [15:11]
  input  logic [1:0]  s_tuser,  // mode [1:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // status [1:0], pass [2], pattern_count [7:3]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mpsf_pkg::*;

  logic [2:0] filtered_priority;
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_cmd;
  res_t       out_res;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {29'd0, filtered_priority} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_priority <= 3'd7;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      filtered_priority <= pwdata[2:0];
    end
  end

  // front: accept and classify transactions into the queue
  mpsf_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  // back: table maintenance and message search
  mpsf_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .filtered_priority(filtered_priority),
    .out_valid(m_tvalid), .out_res(out_res), .out_ready(m_tready)
  );

  assign m_tdata = out_res;

endmodule
